### rtl/powerpc_integer_alu_defines.svh
// Assertion macros shared by the checker of the integer unit.
// Depends on nothing; included by the checker file only.
`ifndef POWERPC_INTEGER_ALU_DEFINES_SVH
`define POWERPC_INTEGER_ALU_DEFINES_SVH
// Implication checked on every rising edge, with reset masking the check.
`define PIA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication.
`define PIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");
`endif

### rtl/pia_pkg.sv
// Package of the integer unit: operation codes, command and status types.
// Depends on nothing.
package pia_pkg;
   typedef enum logic [5:0] {
      OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_ADDE = 6'd2, OP_ADDI = 6'd3, OP_ADDIC = 6'd4,
      OP_ADDIC_RC = 6'd5, OP_ADDIS = 6'd6, OP_ADDME = 6'd7, OP_ADDZE = 6'd8,
      OP_SUBF = 6'd9, OP_SUBFC = 6'd10, OP_SUBFE = 6'd11, OP_SUBFIC = 6'd12,
      OP_SUBFME = 6'd13, OP_SUBFZE = 6'd14, OP_NEG = 6'd15, OP_CMP = 6'd16,
      OP_CMPL = 6'd17, OP_CMPI = 6'd18, OP_CMPLI = 6'd19, OP_MULLI = 6'd20,
      OP_MULHW = 6'd21, OP_MULHWU = 6'd22, OP_MULLW = 6'd23, OP_DIVW = 6'd24,
      OP_DIVWU = 6'd25, OP_EXTSB = 6'd26, OP_EXTSH = 6'd27, OP_CNTLZW = 6'd28,
      OP_AND = 6'd29, OP_ANDC = 6'd30, OP_OR = 6'd31, OP_ORC = 6'd32, OP_XOR = 6'd33,
      OP_NAND = 6'd34, OP_NOR = 6'd35, OP_EQV = 6'd36, OP_ANDI = 6'd37,
      OP_ANDIS = 6'd38, OP_ORI = 6'd39, OP_ORIS = 6'd40, OP_XORI = 6'd41,
      OP_XORIS = 6'd42, OP_SLW = 6'd43, OP_SRW = 6'd44, OP_SRAW = 6'd45,
      OP_SRAWI = 6'd46, OP_RLWIMI = 6'd47, OP_RLWINM = 6'd48, OP_RLWNM = 6'd49
   } op_type;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [5:0]  operation;
      logic [31:0] src_a;
      logic [31:0] src_b;
      logic [31:0] old_dest;
      logic [15:0] immediate;
      logic [4:0]  shift_amount;
      logic [4:0]  mask_begin;
      logic [4:0]  mask_end;
      logic        record_flag;
      logic        overflow_enable;
      logic        ra_is_zero;
      logic [2:0]  cr_target;
   } req_type;

   typedef struct packed {
      logic [31:0] result;
      logic        writes_register;
      logic [3:0]  cr_value;
      logic [2:0]  cr_index;
      logic        writes_cr;
      logic        carry_out;
      logic        overflow_out;
      logic        summary_overflow_out;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the request operands
      logic mul_step;   // register the multiplier product
      logic div_init;   // start the divider
      logic div_step;   // one restoring step
      logic finish;     // form the result and update XER
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_last;
   } status_type;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [3:0] cmp_bits(input logic [31:0] x, input logic [31:0] y,
                                           input logic is_signed);
      logic [31:0] xs;
      logic [31:0] ys;
      xs = is_signed ? (x ^ SIGN_BIT) : x;
      ys = is_signed ? (y ^ SIGN_BIT) : y;
      return (xs < ys) ? 4'b1000 : (xs > ys) ? 4'b0100 : 4'b0010;
   endfunction

   function automatic logic [31:0] make_mask(input logic [4:0] mb, input logic [4:0] me);
      logic [31:0] from_m;
      logic [31:0] to_m;
      from_m = ALL_ONES >> mb;
      to_m = ~((ALL_ONES >> me) >> 1);
      return (mb <= me) ? (from_m & to_m) : (from_m | to_m);
   endfunction
endpackage

### rtl/pia_stream_if.sv
// Valid/ready channel carrying one payload of a given type.
// Depends on pia_pkg.
interface pia_req_if (input logic clock);
   logic               valid;
   logic               ready;
   pia_pkg::req_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface pia_rsp_if (input logic clock);
   logic               valid;
   logic               ready;
   pia_pkg::rsp_type   payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/pia_control.sv
// Sequencer of the integer unit: accepts a request, steps the multiplier
// or divider, and holds the response until it is taken. Depends on pia_pkg.
module pia_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pia_pkg::status_type  status,
   output pia_pkg::cmd_type     cmd
);
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001, ST_MUL = 5'b00010, ST_DIV = 5'b00100,
      ST_DONE = 5'b01000, ST_SEND = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      take;
   logic      sent;

   assign sent = rsp_valid && rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) || ((state_ff == ST_SEND) && rsp_ready);
   assign take = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_SEND);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      cmd.load = take;
      case (state_ff)
         ST_IDLE: begin
            if (take) state_in = ST_DONE;
         end
         ST_SEND: begin
            if (take) state_in = ST_DONE;
            else if (sent) state_in = ST_IDLE;
         end
         ST_DONE: begin
            if (status.is_mul) begin
               cmd.mul_step = 1'b1;
               state_in = ST_MUL;
            end else if (status.is_div) begin
               cmd.div_init = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.finish = 1'b1;
               state_in = ST_SEND;
            end
         end
         ST_MUL: begin
            cmd.finish = 1'b1;
            state_in = ST_SEND;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

### rtl/pia_datapath.sv
// Datapath of the integer unit: operand registers, adder, logic, shifter,
// multiplier, restoring divider, XER bits and response register. Depends on pia_pkg.
module pia_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  pia_pkg::req_type     req,
   input  pia_pkg::cmd_type     cmd,
   output pia_pkg::status_type  status,
   output pia_pkg::rsp_type     rsp
);
   pia_pkg::req_type q_ff;
   logic [63:0] prod_ff;
   logic [31:0] quot_ff, rem_ff, dvs_ff;
   logic [5:0]  cnt_ff;
   logic        ca_ff, ov_ff, so_ff;
   pia_pkg::rsp_type rsp_ff;

   pia_pkg::op_type op;
   logic [31:0] a, b, simm;
   logic        is_div;

   assign op = pia_pkg::op_type'(q_ff.operation);
   assign a = q_ff.src_a;
   assign b = q_ff.src_b;
   assign simm = pia_pkg::sext16(q_ff.immediate);
   assign is_div = (op == pia_pkg::OP_DIVW) || (op == pia_pkg::OP_DIVWU);

   assign status.is_mul = (op == pia_pkg::OP_MULHW) || (op == pia_pkg::OP_MULHWU) ||
                          (op == pia_pkg::OP_MULLW) || (op == pia_pkg::OP_MULLI);
   assign status.is_div = is_div;
   assign status.div_last = (cnt_ff == 6'(pia_pkg::DIV_STEPS - 1));
   assign rsp = rsp_ff;

   // Divider operand magnitudes.
   logic        sgn_div;
   logic [31:0] mag_a, mag_b;
   assign sgn_div = (op == pia_pkg::OP_DIVW);
   assign mag_a = (sgn_div && a[31]) ? (32'd0 - a) : a;
   assign mag_b = (sgn_div && b[31]) ? (32'd0 - b) : b;

   logic [32:0] trial;
   assign trial = {rem_ff, quot_ff[31]} - {1'b0, dvs_ff};

   // Multiplier operands.
   logic [31:0] mul_b;
   assign mul_b = (op == pia_pkg::OP_MULLI) ? simm : b;

   always_ff @(posedge clock) begin
      if (cmd.load) q_ff <= req;
      if (cmd.mul_step) prod_ff <= {32'd0, a} * {32'd0, mul_b};
      if (cmd.div_init) begin
         quot_ff <= mag_a;
         rem_ff <= '0;
         dvs_ff <= mag_b;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quot_ff <= {quot_ff[30:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quot_ff[31]};
            quot_ff <= {quot_ff[30:0], 1'b0};
         end
      end
   end

   // Result formation.
   logic [31:0] add_x, add_y, res, rot, msk, hi_s, rot_src;
   logic        add_ci, set_ca, ov_ok, rec, cmp, wr, cy, ov, sra_cy, ca_n, ov_n, so_n;
   logic [32:0] sum;
   logic [3:0]  crv;
   logic [5:0]  sa;
   logic [4:0]  rn, clz;

   always_comb begin
      add_x = a; add_y = b; add_ci = 1'b0;
      case (op)
         pia_pkg::OP_ADDE, pia_pkg::OP_ADDZE: add_ci = ca_ff;
         pia_pkg::OP_ADDME: begin add_y = pia_pkg::ALL_ONES; add_ci = ca_ff; end
         pia_pkg::OP_ADDIC, pia_pkg::OP_ADDIC_RC: add_y = simm;
         pia_pkg::OP_SUBF, pia_pkg::OP_SUBFC: begin add_x = ~a; add_ci = 1'b1; end
         pia_pkg::OP_SUBFE: begin add_x = ~a; add_ci = ca_ff; end
         pia_pkg::OP_SUBFIC: begin add_x = ~a; add_y = simm; add_ci = 1'b1; end
         pia_pkg::OP_SUBFME: begin add_x = ~a; add_y = pia_pkg::ALL_ONES; add_ci = ca_ff; end
         pia_pkg::OP_SUBFZE: begin add_x = ~a; add_y = '0; add_ci = ca_ff; end
         pia_pkg::OP_NEG: begin add_x = ~a; add_y = '0; add_ci = 1'b1; end
         default: ;
      endcase
      if (op == pia_pkg::OP_ADDZE) add_y = '0;
   end
   assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_ci};

   always_comb begin
      clz = 5'd31;
      for (int i = 0; i < 32; i++) if (a[i]) clz = 5'(31 - i);
   end

   assign sa = (op == pia_pkg::OP_SRAWI) ? {1'b0, q_ff.shift_amount} : b[5:0];
   assign rn = (op == pia_pkg::OP_RLWNM) ? b[4:0] : q_ff.shift_amount;
   assign rot_src = a;
   assign rot = (rot_src << rn) | (rot_src >> (6'd32 - {1'b0, rn}));
   assign msk = pia_pkg::make_mask(q_ff.mask_begin, q_ff.mask_end);
   assign hi_s = prod_ff[63:32] - (a[31] ? mul_b : 32'd0) - (mul_b[31] ? a : 32'd0);

   always_comb begin
      res = '0; cy = 1'b0; ov = 1'b0; set_ca = 1'b0; ov_ok = 1'b0;
      rec = q_ff.record_flag; cmp = 1'b0; wr = 1'b1; crv = '0;
      sra_cy = 1'b0;
      case (op)
         pia_pkg::OP_ADD, pia_pkg::OP_SUBF, pia_pkg::OP_NEG: begin
            res = sum[31:0]; ov_ok = 1'b1;
            ov = (add_x[31] ^ res[31]) & (add_y[31] ^ res[31]);
         end
         pia_pkg::OP_ADDC, pia_pkg::OP_ADDE, pia_pkg::OP_ADDME, pia_pkg::OP_ADDZE,
         pia_pkg::OP_SUBFC, pia_pkg::OP_SUBFE, pia_pkg::OP_SUBFME, pia_pkg::OP_SUBFZE: begin
            res = sum[31:0]; cy = sum[32]; set_ca = 1'b1; ov_ok = 1'b1;
            ov = (add_x[31] ^ res[31]) & (add_y[31] ^ res[31]);
         end
         pia_pkg::OP_ADDIC, pia_pkg::OP_SUBFIC: begin
            res = sum[31:0]; cy = sum[32]; set_ca = 1'b1; rec = 1'b0;
         end
         pia_pkg::OP_ADDIC_RC: begin
            res = sum[31:0]; cy = sum[32]; set_ca = 1'b1; rec = 1'b1;
         end
         pia_pkg::OP_ADDI: begin
            res = (q_ff.ra_is_zero ? 32'd0 : a) + simm; rec = 1'b0;
         end
         pia_pkg::OP_ADDIS: begin
            res = (q_ff.ra_is_zero ? 32'd0 : a) + {q_ff.immediate, 16'd0}; rec = 1'b0;
         end
         pia_pkg::OP_CMP: begin cmp = 1'b1; crv = pia_pkg::cmp_bits(a, b, 1'b1); end
         pia_pkg::OP_CMPL: begin cmp = 1'b1; crv = pia_pkg::cmp_bits(a, b, 1'b0); end
         pia_pkg::OP_CMPI: begin cmp = 1'b1; crv = pia_pkg::cmp_bits(a, simm, 1'b1); end
         pia_pkg::OP_CMPLI: begin
            cmp = 1'b1; crv = pia_pkg::cmp_bits(a, {16'd0, q_ff.immediate}, 1'b0);
         end
         pia_pkg::OP_MULLI: begin res = prod_ff[31:0]; rec = 1'b0; end
         pia_pkg::OP_MULHW: res = hi_s;
         pia_pkg::OP_MULHWU: res = prod_ff[63:32];
         pia_pkg::OP_MULLW: begin
            res = prod_ff[31:0]; ov_ok = 1'b1;
            ov = (hi_s != {32{prod_ff[31]}});
         end
         pia_pkg::OP_DIVW: begin
            ov_ok = 1'b1;
            if (b == 32'd0 || (b == pia_pkg::ALL_ONES && a == pia_pkg::SIGN_BIT)) begin
               ov = 1'b1; res = (b == 32'd0 && !a[31]) ? 32'd0 : pia_pkg::ALL_ONES;
            end else res = (a[31] ^ b[31]) ? (32'd0 - quot_ff) : quot_ff;
         end
         pia_pkg::OP_DIVWU: begin
            ov_ok = 1'b1;
            if (b == 32'd0) ov = 1'b1;
            else res = quot_ff;
         end
         pia_pkg::OP_EXTSB: res = {{24{a[7]}}, a[7:0]};
         pia_pkg::OP_EXTSH: res = pia_pkg::sext16(a[15:0]);
         pia_pkg::OP_CNTLZW: res = (a == 32'd0) ? 32'd32 : {27'd0, clz};
         pia_pkg::OP_AND: res = a & b;
         pia_pkg::OP_ANDC: res = a & ~b;
         pia_pkg::OP_OR: res = a | b;
         pia_pkg::OP_ORC: res = a | ~b;
         pia_pkg::OP_XOR: res = a ^ b;
         pia_pkg::OP_NAND: res = ~(a & b);
         pia_pkg::OP_NOR: res = ~(a | b);
         pia_pkg::OP_EQV: res = ~(a ^ b);
         pia_pkg::OP_ANDI: begin res = a & {16'd0, q_ff.immediate}; rec = 1'b1; end
         pia_pkg::OP_ANDIS: begin res = a & {q_ff.immediate, 16'd0}; rec = 1'b1; end
         pia_pkg::OP_ORI: begin res = a | {16'd0, q_ff.immediate}; rec = 1'b0; end
         pia_pkg::OP_ORIS: begin res = a | {q_ff.immediate, 16'd0}; rec = 1'b0; end
         pia_pkg::OP_XORI: begin res = a ^ {16'd0, q_ff.immediate}; rec = 1'b0; end
         pia_pkg::OP_XORIS: begin res = a ^ {q_ff.immediate, 16'd0}; rec = 1'b0; end
         pia_pkg::OP_SLW: res = b[5] ? 32'd0 : (a << b[4:0]);
         pia_pkg::OP_SRW: res = b[5] ? 32'd0 : (a >> b[4:0]);
         pia_pkg::OP_SRAW, pia_pkg::OP_SRAWI: begin
            set_ca = 1'b1;
            if (sa[5]) begin
               res = {32{a[31]}}; cy = a[31];
            end else begin
               res = 32'($signed(a) >>> sa[4:0]);
               cy = a[31] && ((a & ~(pia_pkg::ALL_ONES << sa[4:0])) != 32'd0);
            end
         end
         pia_pkg::OP_RLWIMI: res = (q_ff.old_dest & ~msk) | (rot & msk);
         pia_pkg::OP_RLWINM, pia_pkg::OP_RLWNM: res = rot & msk;
         default: begin wr = 1'b0; rec = 1'b0; end
      endcase
      if (cmp) rec = 1'b0;
      sra_cy = cy;
   end

   always_comb begin
      ca_n = set_ca ? sra_cy : ca_ff;
      ov_n = ov_ff; so_n = so_ff;
      if (ov_ok && q_ff.overflow_enable) begin
         ov_n = ov;
         so_n = so_ff | ov;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= 1'b0; ov_ff <= 1'b0; so_ff <= 1'b0;
      end else if (cmd.finish) begin
         ca_ff <= ca_n; ov_ff <= ov_n; so_ff <= so_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.result <= cmp ? 32'd0 : res;
         rsp_ff.writes_register <= wr && !cmp;
         rsp_ff.cr_value <= cmp ? (crv | {3'd0, so_n}) :
                            rec ? (pia_pkg::cmp_bits(res, 32'd0, 1'b1) | {3'd0, so_n}) : 4'd0;
         rsp_ff.cr_index <= cmp ? q_ff.cr_target : 3'd0;
         rsp_ff.writes_cr <= cmp || rec;
         rsp_ff.carry_out <= ca_n;
         rsp_ff.overflow_out <= ov_n;
         rsp_ff.summary_overflow_out <= so_n;
      end
   end
endmodule

### rtl/powerpc_integer_alu.sv
// PowerPC 32-bit fixed-point integer unit, one instruction per request
// transfer and one response transfer per request.
// Channels: req (operation and operands) and rsp (result, CR field and
// XER bits), both valid/ready; a transfer happens when both are high.
// The operands are registered on the request transfer; most operations
// then form the result into the response register, the multiplies first
// register one 32x32 product, and the divides first run a restoring
// divider one quotient bit a cycle. A new request is taken in the cycle
// the pending response is transferred and not while an instruction runs.
// While the receiver stalls the response register holds its value and
// no further request is taken.
// Reset clears the XER carry, overflow and summary-overflow bits and
// returns the sequencer to idle.
// Depends on pia_pkg, the channel interfaces, pia_control and pia_datapath.
module powerpc_integer_alu (
   input logic         clock,
   input logic         reset,
   pia_req_if.sink     req_ch,
   pia_rsp_if.source   rsp_ch
);
   pia_pkg::cmd_type    cmd;
   pia_pkg::status_type status;

   pia_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pia_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch.payload),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_ch.payload)
   );
endmodule

### rtl/pia_checker.sv
// Port-level checks of the integer unit, bound to the top level.
// Depends on pia_pkg and powerpc_integer_alu_defines.svh.
`include "powerpc_integer_alu_defines.svh"
module pia_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pia_pkg::rsp_type rsp
);
   `PIA_ASSERT_IMPL(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, ##1 rsp_valid)
   `PIA_ASSERT_NEXT(a_req_then_busy, clock, reset, req_valid && req_ready, !rsp_valid)
   `PIA_ASSERT_IMPL(a_so_sticky, clock, reset, rsp_valid && rsp.overflow_out, rsp.summary_overflow_out)
   `PIA_ASSERT_IMPL(a_cr_zero, clock, reset, rsp_valid && !rsp.writes_cr, rsp.cr_value == 4'd0)
   `PIA_ASSERT_IMPL(a_ready_gate, clock, reset, rsp_valid && !rsp_ready, !req_ready)
endmodule

bind powerpc_integer_alu pia_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp       (rsp_ch.payload)
);

### sim/tb_top.sv
// Self-checking testbench of the PowerPC integer unit: a directed table, then random
// instructions, each response held to a known row value or a built-in prediction.
// Depends on pia_pkg, the channel interfaces and powerpc_integer_alu.
module tb_top;
   localparam int RANDOM_ITEMS = 1100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS = 20;
   localparam int REQ_BITS = $bits(pia_pkg::req_type);

   typedef struct {
      pia_pkg::req_type    cmd;
      logic                known;
      pia_pkg::rsp_type    rsp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pia_req_if req_ch (clock);
   pia_rsp_if rsp_ch (clock);

   powerpc_integer_alu uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always #5 clock = ~clock;

   logic             xer_ca = 1'b0;
   logic             xer_ov = 1'b0;
   logic             xer_so = 1'b0;
   pia_pkg::rsp_type expected_rsps[$];
   int               mismatches = 0;
   int               idle_cycles = 0;
   bit               stimulus_done = 1'b0;
   row_type          table_rows[DIRECTED_ROWS];

   function automatic logic [32:0] add_bits(input logic [31:0] x, input logic [31:0] y,
                                            input logic cin, output logic ov);
      logic [32:0] s;
      s = {1'b0, x} + {1'b0, y} + {32'd0, cin};
      ov = (x[31] ^ s[31]) & (y[31] ^ s[31]);
      return s;
   endfunction

   function automatic logic [3:0] compare_bits(input logic [31:0] x, input logic [31:0] y,
                                               input logic sgn);
      if (sgn) begin
         x = x ^ 32'h8000_0000;
         y = y ^ 32'h8000_0000;
      end
      return (x < y) ? 4'b1000 : (x > y) ? 4'b0100 : 4'b0010;
   endfunction

   function automatic logic [31:0] rotate_left(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] rotate_mask(input logic [4:0] mb, input logic [4:0] me);
      logic [31:0] m;
      for (int i = 0; i < 32; i++)
         m[31 - i] = (mb <= me) ? (i >= mb && i <= me) : (i >= mb || i <= me);
      return m;
   endfunction

   function automatic logic [31:0] shift_right_arith(input logic [31:0] x, input logic [5:0] sa,
                                                     output logic cy);
      logic [31:0] lost;
      if (sa >= 6'd32) begin
         cy = x[31];
         return {32{x[31]}};
      end
      lost = x & ((32'd1 << sa) - 32'd1);
      cy = x[31] && (lost != 32'd0);
      return $unsigned($signed(x) >>> sa);
   endfunction

   // Works out the response of one instruction and advances the XER copy.
   function automatic pia_pkg::rsp_type execute_instruction(input pia_pkg::req_type c);
      pia_pkg::rsp_type r;
      logic [32:0]      s;
      logic [31:0]      a, b, si, res, m, ma, mb2;
      logic [63:0]      p;
      logic [3:0]       crv;
      logic             cy, ov, wr, rec, set_ca, ov_ok, is_cmp;
      int               n;
      a = c.src_a;
      b = c.src_b;
      si = {{16{c.immediate[15]}}, c.immediate};
      res = 32'd0; cy = 1'b0; ov = 1'b0; crv = 4'd0; s = 33'd0;
      wr = 1'b1; rec = 1'b0; set_ca = 1'b0; ov_ok = 1'b0; is_cmp = 1'b0;
      case (c.operation)
         pia_pkg::OP_ADD: begin
            s = add_bits(a, b, 1'b0, ov); ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_ADDC: begin
            s = add_bits(a, b, 1'b0, ov); set_ca = 1'b1; ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_ADDE: begin
            s = add_bits(a, b, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_ADDI: s = {1'b0, (c.ra_is_zero ? 32'd0 : a) + si};
         pia_pkg::OP_ADDIC: begin s = add_bits(a, si, 1'b0, ov); set_ca = 1'b1; end
         pia_pkg::OP_ADDIC_RC: begin
            s = add_bits(a, si, 1'b0, ov); set_ca = 1'b1; rec = 1'b1;
         end
         pia_pkg::OP_ADDIS: s = {1'b0, (c.ra_is_zero ? 32'd0 : a) + {c.immediate, 16'd0}};
         pia_pkg::OP_ADDME: begin
            s = add_bits(a, 32'hFFFF_FFFF, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1;
            rec = c.record_flag;
         end
         pia_pkg::OP_ADDZE: begin
            s = add_bits(a, 32'd0, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1;
            rec = c.record_flag;
         end
         pia_pkg::OP_SUBF: begin
            s = add_bits(~a, b, 1'b1, ov); ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_SUBFC: begin
            s = add_bits(~a, b, 1'b1, ov); set_ca = 1'b1; ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_SUBFE: begin
            s = add_bits(~a, b, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_SUBFIC: begin s = add_bits(~a, si, 1'b1, ov); set_ca = 1'b1; end
         pia_pkg::OP_SUBFME: begin
            s = add_bits(~a, 32'hFFFF_FFFF, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1;
            rec = c.record_flag;
         end
         pia_pkg::OP_SUBFZE: begin
            s = add_bits(~a, 32'd0, xer_ca, ov); set_ca = 1'b1; ov_ok = 1'b1;
            rec = c.record_flag;
         end
         pia_pkg::OP_NEG: begin
            s = add_bits(~a, 32'd0, 1'b1, ov); ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_CMP: begin is_cmp = 1'b1; crv = compare_bits(a, b, 1'b1); end
         pia_pkg::OP_CMPL: begin is_cmp = 1'b1; crv = compare_bits(a, b, 1'b0); end
         pia_pkg::OP_CMPI: begin is_cmp = 1'b1; crv = compare_bits(a, si, 1'b1); end
         pia_pkg::OP_CMPLI: begin
            is_cmp = 1'b1; crv = compare_bits(a, {16'd0, c.immediate}, 1'b0);
         end
         default: ;
      endcase
      res = s[31:0];
      cy = s[32];
      case (c.operation)
         pia_pkg::OP_MULLI: begin p = $signed(a) * $signed(si); res = p[31:0]; end
         pia_pkg::OP_MULHW: begin
            p = $signed(a) * $signed(b); res = p[63:32]; rec = c.record_flag;
         end
         pia_pkg::OP_MULLW: begin
            p = $signed(a) * $signed(b);
            res = p[31:0];
            ov = p[63:32] != {32{p[31]}};
            ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_MULHWU: begin
            p = {32'd0, a} * {32'd0, b}; res = p[63:32]; rec = c.record_flag;
         end
         pia_pkg::OP_DIVW: begin
            if (b == 32'd0 && !a[31]) begin res = 32'd0; ov = 1'b1; end
            else if (b == 32'd0 || (b == 32'hFFFF_FFFF && a == 32'h8000_0000)) begin
               res = 32'hFFFF_FFFF; ov = 1'b1;
            end else begin
               ma = a[31] ? -a : a;
               mb2 = b[31] ? -b : b;
               res = ma / mb2;
               if (a[31] ^ b[31]) res = -res;
            end
            ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_DIVWU: begin
            if (b == 32'd0) begin res = 32'd0; ov = 1'b1; end else res = a / b;
            ov_ok = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_EXTSB: begin res = {{24{a[7]}}, a[7:0]}; rec = c.record_flag; end
         pia_pkg::OP_EXTSH: begin res = {{16{a[15]}}, a[15:0]}; rec = c.record_flag; end
         pia_pkg::OP_CNTLZW: begin
            n = 32;
            for (int i = 0; i < 32; i++)
               if (a[i]) n = 31 - i;
            res = n; rec = c.record_flag;
         end
         pia_pkg::OP_AND: begin res = a & b; rec = c.record_flag; end
         pia_pkg::OP_ANDC: begin res = a & ~b; rec = c.record_flag; end
         pia_pkg::OP_OR: begin res = a | b; rec = c.record_flag; end
         pia_pkg::OP_ORC: begin res = a | ~b; rec = c.record_flag; end
         pia_pkg::OP_XOR: begin res = a ^ b; rec = c.record_flag; end
         pia_pkg::OP_NAND: begin res = ~(a & b); rec = c.record_flag; end
         pia_pkg::OP_NOR: begin res = ~(a | b); rec = c.record_flag; end
         pia_pkg::OP_EQV: begin res = ~(a ^ b); rec = c.record_flag; end
         pia_pkg::OP_ANDI: begin res = a & {16'd0, c.immediate}; rec = 1'b1; end
         pia_pkg::OP_ANDIS: begin res = a & {c.immediate, 16'd0}; rec = 1'b1; end
         pia_pkg::OP_ORI: res = a | {16'd0, c.immediate};
         pia_pkg::OP_ORIS: res = a | {c.immediate, 16'd0};
         pia_pkg::OP_XORI: res = a ^ {16'd0, c.immediate};
         pia_pkg::OP_XORIS: res = a ^ {c.immediate, 16'd0};
         pia_pkg::OP_SLW: begin res = b[5] ? 32'd0 : a << b[4:0]; rec = c.record_flag; end
         pia_pkg::OP_SRW: begin res = b[5] ? 32'd0 : a >> b[4:0]; rec = c.record_flag; end
         pia_pkg::OP_SRAW: begin
            res = shift_right_arith(a, b[5:0], cy); set_ca = 1'b1; rec = c.record_flag;
         end
         pia_pkg::OP_SRAWI: begin
            res = shift_right_arith(a, {1'b0, c.shift_amount}, cy); set_ca = 1'b1;
            rec = c.record_flag;
         end
         pia_pkg::OP_RLWIMI: begin
            m = rotate_mask(c.mask_begin, c.mask_end);
            res = (c.old_dest & ~m) | (rotate_left(a, c.shift_amount) & m);
            rec = c.record_flag;
         end
         pia_pkg::OP_RLWINM: begin
            res = rotate_left(a, c.shift_amount) & rotate_mask(c.mask_begin, c.mask_end);
            rec = c.record_flag;
         end
         pia_pkg::OP_RLWNM: begin
            res = rotate_left(a, b[4:0]) & rotate_mask(c.mask_begin, c.mask_end);
            rec = c.record_flag;
         end
         default: if (c.operation > pia_pkg::OP_RLWNM) wr = 1'b0;
      endcase
      if (set_ca) xer_ca = cy;
      if (ov_ok && c.overflow_enable) begin
         xer_ov = ov;
         if (ov) xer_so = 1'b1;
      end
      r = '0;
      if (is_cmp) begin
         r.cr_value = crv | {3'd0, xer_so};
         r.cr_index = c.cr_target;
         wr = 1'b0;
         res = 32'd0;
      end else if (rec) begin
         r.cr_value = compare_bits(res, 32'd0, 1'b1) | {3'd0, xer_so};
      end
      r.result = res;
      r.writes_register = wr;
      r.writes_cr = is_cmp || rec;
      r.carry_out = xer_ca;
      r.overflow_out = xer_ov;
      r.summary_overflow_out = xer_so;
      return r;
   endfunction

   function automatic pia_pkg::req_type make_cmd(input pia_pkg::op_type op,
                                                 input logic [31:0] a,
                                                 input logic [31:0] b, input logic [15:0] imm,
                                                 input logic rc, input logic oe);
      pia_pkg::req_type c;
      c = '0;
      c.operation = op;
      c.src_a = a;
      c.src_b = b;
      c.immediate = imm;
      c.record_flag = rc;
      c.overflow_enable = oe;
      c.old_dest = 32'h5A5A_A5A5;
      c.mask_begin = 5'd31;
      c.cr_target = 3'd7;
      return c;
   endfunction

   function automatic pia_pkg::req_type random_cmd();
      pia_pkg::req_type c;
      logic [159:0]     raw;
      int               pick;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      c = raw[REQ_BITS-1:0];
      c.operation = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(50, 63))
                                                 : 6'($urandom_range(0, 49));
      pick = $urandom_range(0, 9);
      if (pick == 0) c.src_b = 32'd0;
      else if (pick == 1) c.src_b = 32'hFFFF_FFFF;
      else if (pick == 2) c.src_b = $urandom_range(0, 70);
      pick = $urandom_range(0, 9);
      if (pick == 0) c.src_a = 32'h8000_0000;
      else if (pick == 1) c.src_a = 32'd0;
      else if (pick == 2) c.src_a = 32'h7FFF_FFFF;
      else if (pick == 3) c.src_a = c.src_a >> $urandom_range(0, 31);
      return c;
   endfunction

   initial begin
      table_rows[0] = '{make_cmd(pia_pkg::OP_ADDC, 32'hFFFF_FFFF, 32'd1, 16'd0, 1'b1, 1'b1),
                        1'b1,
                        pia_pkg::rsp_type'({32'd0, 1'b1, 4'b0010, 3'd0, 1'b1, 1'b1, 1'b0,
                                            1'b0})};
      table_rows[1] = '{make_cmd(pia_pkg::OP_ADDE, 32'h7FFF_FFFF, 32'd0, 16'd0, 1'b1, 1'b1),
                        1'b1,
                        pia_pkg::rsp_type'({32'h8000_0000, 1'b1, 4'b1001, 3'd0, 1'b1, 1'b0,
                                            1'b1, 1'b1})};
      table_rows[2] = '{make_cmd(pia_pkg::OP_DIVW, 32'h8000_0000, 32'hFFFF_FFFF, 16'd0,
                                 1'b0, 1'b1), 1'b0, '0};
      table_rows[3] = '{make_cmd(pia_pkg::OP_DIVW, 32'hFFFF_FFF0, 32'd0, 16'd0, 1'b1, 1'b1),
                        1'b0, '0};
      table_rows[4] = '{make_cmd(pia_pkg::OP_DIVW, 32'd5, 32'd0, 16'd0, 1'b1, 1'b1),
                        1'b0, '0};
      table_rows[5] = '{make_cmd(pia_pkg::OP_DIVWU, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b1, 1'b1),
                        1'b0, '0};
      table_rows[6] = '{make_cmd(pia_pkg::OP_DIVWU, 32'hFFFF_FFFF, 32'd7, 16'd0, 1'b1, 1'b0),
                        1'b0, '0};
      table_rows[7] = '{make_cmd(pia_pkg::OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0,
                                 1'b0, 1'b0), 1'b0, '0};
      table_rows[8] = '{make_cmd(pia_pkg::OP_CMPLI, 32'h0000_FFFF, 32'd0, 16'hFFFF,
                                 1'b0, 1'b0), 1'b0, '0};
      table_rows[9] = '{make_cmd(pia_pkg::OP_MULHW, 32'h8000_0000, 32'h8000_0000, 16'd0,
                                 1'b1, 1'b0), 1'b0, '0};
      table_rows[10] = '{make_cmd(pia_pkg::OP_MULLW, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0,
                                  1'b1, 1'b1), 1'b0, '0};
      table_rows[11] = '{make_cmd(pia_pkg::OP_SRAW, 32'h8000_0001, 32'd63, 16'd0, 1'b1, 1'b0),
                         1'b0, '0};
      table_rows[12] = '{make_cmd(pia_pkg::OP_SLW, 32'hFFFF_FFFF, 32'd32, 16'd0, 1'b1, 1'b0),
                         1'b0, '0};
      table_rows[13] = '{make_cmd(pia_pkg::OP_CNTLZW, 32'd0, 32'd0, 16'd0, 1'b1, 1'b0),
                         1'b0, '0};
      table_rows[14] = '{make_cmd(pia_pkg::OP_RLWNM, 32'h1234_5678, 32'd0, 16'd0, 1'b1, 1'b0),
                         1'b0, '0};
      table_rows[15] = '{make_cmd(pia_pkg::OP_ADDI, 32'hDEAD_BEEF, 32'd0, 16'h8000,
                                  1'b0, 1'b0), 1'b0, '0};
      table_rows[15].cmd.ra_is_zero = 1'b1;
      table_rows[16] = '{make_cmd(pia_pkg::OP_SUBFZE, 32'hFFFF_FFFF, 32'd0, 16'd0,
                                  1'b1, 1'b1), 1'b0, '0};
      table_rows[17] = '{make_cmd(pia_pkg::OP_RLWIMI, 32'hF0F0_F0F0, 32'd0, 16'd0,
                                  1'b1, 1'b0), 1'b0, '0};
      table_rows[17].cmd.shift_amount = 5'd31;
      table_rows[17].cmd.mask_begin = 5'd4;
      table_rows[17].cmd.mask_end = 5'd27;
      table_rows[18] = '{make_cmd(pia_pkg::OP_NEG, 32'h8000_0000, 32'd0, 16'd0, 1'b1, 1'b1),
                         1'b0, '0};
      table_rows[19] = '{make_cmd(pia_pkg::op_type'(6'd63), 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  16'hFFFF, 1'b1, 1'b1), 1'b0, '0};
   end

   task automatic send_cmd(input pia_pkg::req_type c, input logic known,
                           input pia_pkg::rsp_type want);
      pia_pkg::rsp_type predicted;
      int               wait_cycles;
      wait_cycles = $urandom_range(0, 19);
      if (wait_cycles > 0) begin
         req_ch.valid <= 1'b0;
         repeat (wait_cycles) @(posedge clock);
      end
      req_ch.payload <= c;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predicted = execute_instruction(c);
      expected_rsps.push_back(known ? want : predicted);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (table_rows[i])
         send_cmd(table_rows[i].cmd, table_rows[i].known, table_rows[i].rsp);
      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_cmd(random_cmd(), 1'b0, '0);
      req_ch.valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   int stall_left = 0;
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
         stall_left = $urandom_range(0, 19);
         rsp_ch.ready <= (stall_left == 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= (stall_left == 0);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", rsp_ch.payload);
         end else if (rsp_ch.payload !== expected_rsps[0]) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %p, got %p", expected_rsps[0], rsp_ch.payload);
            void'(expected_rsps.pop_front());
         end else begin
            void'(expected_rsps.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+rtl
rtl/pia_pkg.sv
rtl/pia_stream_if.sv
rtl/pia_control.sv
rtl/pia_datapath.sv
rtl/powerpc_integer_alu.sv
rtl/pia_checker.sv
sim/tb_top.sv
